// ===== hw/rtl/lik_pkg.sv =====
package lik_pkg;

	localparam int CORDIC_ITERATIONS = 16;
	localparam int ANGLE_FRACTION_BITS = 6;
	localparam int AU_BITS = 20;

	localparam int FIELD_W = 16;
	localparam int LINK_W = 14;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 14;

	localparam int ANG_W = 32;
	localparam int ANG_EXT_W = 34;
	localparam int VEC_W = 48;
	localparam int AT_IN_W = 34;
	localparam int NORM_EXP = 40;
	localparam int NORM_STEPS = 7;
	localparam int AT_LAT = 1 + NORM_STEPS + CORDIC_ITERATIONS;
	localparam int SH_W = 5;

	localparam int SQ_IN_W = 62;
	localparam int SQ_STEPS = SQ_IN_W / 2;
	localparam int SQ_REM_W = SQ_STEPS + 1;

	localparam int PIPE_DEPTH = 5 + SQ_STEPS + AT_LAT + 4;

	localparam int OUT_SHIFT = AU_BITS - ANGLE_FRACTION_BITS;
	localparam int OUT_LIM_RAW = 360 * (1 << ANGLE_FRACTION_BITS);
	localparam int OUT_LIM = (OUT_LIM_RAW > 32767) ? 32767 : OUT_LIM_RAW;

	localparam logic signed [ANG_W-1:0] DEG_90 = ANG_W'(90 * (1 << AU_BITS));
	localparam logic signed [ANG_W-1:0] DEG_180 = ANG_W'(180 * (1 << AU_BITS));

	localparam logic [CFG_INDEX_W-1:0] REG_LEG_POSITION = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_UPPER_LINK = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LOWER_LINK = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ABDUCTION_OFFSET = 2'd3;

	localparam logic [1:0] POS_FRONT_RIGHT = 2'd0;
	localparam logic [1:0] POS_FRONT_LEFT = 2'd1;
	localparam logic [1:0] POS_BACK_RIGHT = 2'd2;
	localparam logic [1:0] POS_BACK_LEFT = 2'd3;

	typedef struct packed {
		logic signed [AT_IN_W-1:0] a;
		logic signed [AT_IN_W-1:0] b;
		logic signed [AT_IN_W-1:0] ny;
		logic signed [AT_IN_W-1:0] nz;
		logic signed [AT_IN_W-1:0] ax;
		logic xzero;
		logic bad;
	} side_t;

	typedef struct packed {
		logic xzero;
		logic bad;
	} flag_t;

	function automatic logic signed [ANG_W-1:0] atan_entry(input logic [SH_W-1:0] idx);
		logic signed [ANG_W-1:0] v;
		case (idx)
			5'd0: v = 32'sd47185920;
			5'd1: v = 32'sd27855475;
			5'd2: v = 32'sd14718068;
			5'd3: v = 32'sd7471121;
			5'd4: v = 32'sd3750058;
			5'd5: v = 32'sd1876857;
			5'd6: v = 32'sd938658;
			5'd7: v = 32'sd469357;
			5'd8: v = 32'sd234682;
			5'd9: v = 32'sd117342;
			5'd10: v = 32'sd58671;
			5'd11: v = 32'sd29335;
			5'd12: v = 32'sd14668;
			5'd13: v = 32'sd7334;
			5'd14: v = 32'sd3667;
			5'd15: v = 32'sd1833;
			5'd16: v = 32'sd917;
			5'd17: v = 32'sd458;
			5'd18: v = 32'sd229;
			5'd19: v = 32'sd115;
			5'd20: v = 32'sd57;
			5'd21: v = 32'sd29;
			5'd22: v = 32'sd14;
			5'd23: v = 32'sd7;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [FIELD_W-1:0] to_out(input logic signed [ANG_EXT_W-1:0] v);
		logic signed [ANG_EXT_W:0] t;
		logic signed [ANG_EXT_W:0] r;
		logic signed [FIELD_W-1:0] o;
		t = (ANG_EXT_W+1)'(v) + (ANG_EXT_W+1)'(1 << (OUT_SHIFT - 1));
		r = t >>> OUT_SHIFT;
		if (r > OUT_LIM)
			o = FIELD_W'(OUT_LIM);
		else if (r < -OUT_LIM)
			o = FIELD_W'(-OUT_LIM);
		else
			o = r[FIELD_W-1:0];
		return o;
	endfunction

endpackage

// ===== hw/rtl/lik_sqrt_cell.sv =====
module lik_sqrt_cell (
	input  logic                          clk,
	input  logic                          en,
	input  logic [lik_pkg::SQ_IN_W-1:0]   rad_in,
	input  logic [lik_pkg::SQ_REM_W-1:0]  rem_in,
	input  logic [lik_pkg::SQ_STEPS-1:0]  root_in,
	output logic [lik_pkg::SQ_IN_W-1:0]   rad_out,
	output logic [lik_pkg::SQ_REM_W-1:0]  rem_out,
	output logic [lik_pkg::SQ_STEPS-1:0]  root_out
);
	import lik_pkg::*;

	logic [SQ_REM_W+1:0] rem_sh;
	logic [SQ_REM_W+1:0] trial;
	logic [SQ_REM_W+1:0] diff;

	assign rem_sh = {rem_in, rad_in[SQ_IN_W-1 -: 2]};
	assign trial = {1'b0, root_in, 2'b01};
	assign diff = rem_sh - trial;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_out <= {rad_in[SQ_IN_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_out <= diff[SQ_REM_W-1:0];
				root_out <= {root_in[SQ_STEPS-2:0], 1'b1};
			end else begin
				rem_out <= rem_sh[SQ_REM_W-1:0];
				root_out <= {root_in[SQ_STEPS-2:0], 1'b0};
			end
		end
	end

endmodule

// ===== hw/rtl/lik_cordic_cell.sv =====
module lik_cordic_cell (
	input  logic                             clk,
	input  logic                             en,
	input  logic [lik_pkg::SH_W-1:0]         shift,
	input  logic signed [lik_pkg::ANG_W-1:0] step_angle,
	input  logic signed [lik_pkg::VEC_W-1:0] x_in,
	input  logic signed [lik_pkg::VEC_W-1:0] y_in,
	input  logic signed [lik_pkg::ANG_W-1:0] z_in,
	output logic signed [lik_pkg::VEC_W-1:0] x_out,
	output logic signed [lik_pkg::VEC_W-1:0] y_out,
	output logic signed [lik_pkg::ANG_W-1:0] z_out
);
	import lik_pkg::*;

	logic signed [VEC_W-1:0] xs;
	logic signed [VEC_W-1:0] ys;

	assign xs = x_in >>> shift;
	assign ys = y_in >>> shift;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[VEC_W-1]) begin
				x_out <= x_in + ys;
				y_out <= y_in - xs;
				z_out <= z_in + step_angle;
			end else begin
				x_out <= x_in - ys;
				y_out <= y_in + xs;
				z_out <= z_in - step_angle;
			end
		end
	end

endmodule

// ===== hw/rtl/lik_atan2.sv =====
module lik_atan2 (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [lik_pkg::AT_IN_W-1:0] y_in,
	input  logic signed [lik_pkg::AT_IN_W-1:0] x_in,
	output logic signed [lik_pkg::ANG_W-1:0]   angle
);
	import lik_pkg::*;

	logic signed [VEC_W-1:0] xe;
	logic signed [VEC_W-1:0] ye;
	logic signed [VEC_W-1:0] x_s1;
	logic signed [VEC_W-1:0] y_s1;
	logic signed [ANG_W-1:0] z_s1;
	logic                    zero_s1;

	logic signed [VEC_W-1:0] nx_s [NORM_STEPS];
	logic signed [VEC_W-1:0] ny_s [NORM_STEPS];
	logic signed [ANG_W-1:0] nz_s [NORM_STEPS];
	logic                    nf_s [NORM_STEPS];

	logic signed [VEC_W-1:0] cx_s [CORDIC_ITERATIONS];
	logic signed [VEC_W-1:0] cy_s [CORDIC_ITERATIONS];
	logic signed [ANG_W-1:0] cz_s [CORDIC_ITERATIONS];
	logic                    cf_s [CORDIC_ITERATIONS];

	assign xe = VEC_W'(x_in);
	assign ye = VEC_W'(y_in);

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= (x_in == '0) && (y_in == '0);
			if (x_in[AT_IN_W-1]) begin
				x_s1 <= -xe;
				y_s1 <= -ye;
				z_s1 <= y_in[AT_IN_W-1] ? -DEG_180 : DEG_180;
			end else begin
				x_s1 <= xe;
				y_s1 <= ye;
				z_s1 <= '0;
			end
		end
	end

	for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
		localparam int SH = (j < NORM_STEPS - 1) ? (32 >> j) : 1;
		localparam int LIM = (j < NORM_STEPS - 1) ? NORM_EXP - SH : NORM_EXP;
		localparam logic [VEC_W-1:0] LIM_V = VEC_W'(1) << LIM;
		logic signed [VEC_W-1:0] xi;
		logic signed [VEC_W-1:0] yi;
		logic signed [ANG_W-1:0] zi;
		logic                    fi;
		logic [VEC_W-1:0]        ax;
		logic [VEC_W-1:0]        ay;
		if (j == 0) begin : g_first
			assign xi = x_s1;
			assign yi = y_s1;
			assign zi = z_s1;
			assign fi = zero_s1;
		end else begin : g_next
			assign xi = nx_s[j-1];
			assign yi = ny_s[j-1];
			assign zi = nz_s[j-1];
			assign fi = nf_s[j-1];
		end
		assign ax = xi[VEC_W-1] ? -xi : xi;
		assign ay = yi[VEC_W-1] ? -yi : yi;
		always_ff @(posedge clk) begin
			if (en) begin
				nz_s[j] <= zi;
				nf_s[j] <= fi;
				if (ax < LIM_V && ay < LIM_V) begin
					nx_s[j] <= xi <<< SH;
					ny_s[j] <= yi <<< SH;
				end else begin
					nx_s[j] <= xi;
					ny_s[j] <= yi;
				end
			end
		end
	end

	for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cordic
		logic signed [VEC_W-1:0] xi;
		logic signed [VEC_W-1:0] yi;
		logic signed [ANG_W-1:0] zi;
		logic                    fi;
		if (i == 0) begin : g_first
			assign xi = nx_s[NORM_STEPS-1];
			assign yi = ny_s[NORM_STEPS-1];
			assign zi = nz_s[NORM_STEPS-1];
			assign fi = nf_s[NORM_STEPS-1];
		end else begin : g_next
			assign xi = cx_s[i-1];
			assign yi = cy_s[i-1];
			assign zi = cz_s[i-1];
			assign fi = cf_s[i-1];
		end
		lik_cordic_cell u_cell (
			.clk        (clk),
			.en         (en),
			.shift      (SH_W'(i)),
			.step_angle (atan_entry(SH_W'(i))),
			.x_in       (xi),
			.y_in       (yi),
			.z_in       (zi),
			.x_out      (cx_s[i]),
			.y_out      (cy_s[i]),
			.z_out      (cz_s[i])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				cf_s[i] <= fi;
			end
		end
	end

	assign angle = cf_s[CORDIC_ITERATIONS-1] ? '0 : cz_s[CORDIC_ITERATIONS-1];

endmodule

// ===== hw/rtl/leg_inverse_kinematics_3dof.sv =====
// Three-link leg inverse kinematics, fully pipelined.
// Input channel (in_valid/in_ready): foot target foot_x, foot_y, foot_z, signed 1/16 mm.
// Output channel (out_valid/out_ready): abduction, hip and knee servo angles in
// 1/64 degree, saturated to +-360 degrees, plus the unreachable flag; an
// unreachable target gives zero angles.
// Configuration: cfg_write with cfg_index/cfg_data writes leg_position (0),
// upper_link_length (1), lower_link_length (2), abduction_offset (3); write only
// while no transaction is in flight.
// Throughput: one transaction per cycle while the receiver does not stall. Latency
// is set by the 31-step square-root cell chain and the 24-stage atan2 units
// (quadrant fold, 7 normalize stages, 16 CORDIC cells).
// Reset clears the valid pipeline and loads the registers with 0, 1600, 1600, 960.
// When the receiver stalls the whole pipeline holds and in_ready drops; a result
// waiting in the output register does not block input while out_ready is high.
module leg_inverse_kinematics_3dof (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [lik_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [lik_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [lik_pkg::FIELD_W-1:0]   foot_x,
	input  logic signed [lik_pkg::FIELD_W-1:0]   foot_y,
	input  logic signed [lik_pkg::FIELD_W-1:0]   foot_z,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [lik_pkg::FIELD_W-1:0]   abduction_servo_angle,
	output logic signed [lik_pkg::FIELD_W-1:0]   hip_servo_angle,
	output logic signed [lik_pkg::FIELD_W-1:0]   knee_servo_angle,
	output logic                                 unreachable
);
	import lik_pkg::*;

	logic [1:0]            leg_position_q;
	logic [LINK_W-1:0]     upper_q;
	logic [LINK_W-1:0]     lower_q;
	logic [LINK_W-1:0]     offset_q;

	logic [2*LINK_W-1:0]   l1sq_q;
	logic [2*LINK_W-1:0]   l2sq_q;
	logic [2*LINK_W-1:0]   l3sq_q;
	logic [2*LINK_W+1:0]   sum2_q;
	logic [2*LINK_W-1:0]   dif2_q;
	logic                  lzero_q;
	logic [LINK_W:0]       lsum;
	logic [LINK_W-1:0]     ldif;

	logic                  en;
	logic [PIPE_DEPTH-1:0] vld_q;
	logic                  right_leg;
	logic                  mirror_leg;

	logic signed [16:0]    x_s1;
	logic signed [15:0]    y_s1;
	logic signed [15:0]    z_s1;
	logic signed [33:0]    xp;
	logic signed [31:0]    yp;
	logic signed [31:0]    zp;

	logic [30:0]           xx_s2;
	logic [30:0]           yy_s2;
	logic [30:0]           zz_s2;
	logic signed [16:0]    x_s2;
	logic signed [15:0]    y_s2;
	logic signed [15:0]    z_s2;
	logic [31:0]           q_sum;
	logic [32:0]           qy_sum;

	logic [31:0]           q_s3;
	logic signed [33:0]    d2_s3;
	logic signed [33:0]    e2_s3;
	logic signed [16:0]    x_s3;
	logic signed [15:0]    y_s3;
	logic signed [15:0]    z_s3;
	logic                  bad3;
	logic signed [33:0]    um;
	logic signed [33:0]    wm;
	logic signed [33:0]    am;
	logic signed [33:0]    bm;

	logic                  bad_s4;
	logic [29:0]           u_s4;
	logic [29:0]           w_s4;
	logic signed [AT_IN_W-1:0] a_s4;
	logic signed [AT_IN_W-1:0] b_s4;
	logic [31:0]           e2_s4;
	logic signed [16:0]    x_s4;
	logic signed [15:0]    y_s4;
	logic signed [15:0]    z_s4;
	logic [59:0]           uw;
	logic signed [AT_IN_W-1:0] xe4;

	logic [SQ_IN_W-1:0]    prod_s5;
	logic [SQ_IN_W-1:0]    erad_s5;
	side_t                 side_s5;

	logic [SQ_IN_W-1:0]    pr_rad [SQ_STEPS];
	logic [SQ_REM_W-1:0]   pr_rem [SQ_STEPS];
	logic [SQ_STEPS-1:0]   pr_root [SQ_STEPS];
	logic [SQ_IN_W-1:0]    er_rad [SQ_STEPS];
	logic [SQ_REM_W-1:0]   er_rem [SQ_STEPS];
	logic [SQ_STEPS-1:0]   er_root [SQ_STEPS];
	side_t                 sd_s6 [SQ_STEPS];
	flag_t                 fd_s7 [AT_LAT];

	side_t                 side6;
	logic signed [AT_IN_W-1:0] s_ext;
	logic signed [AT_IN_W-1:0] es_ext;
	logic signed [AT_IN_W-1:0] l3_ext;
	logic signed [ANG_W-1:0]   alpha;
	logic signed [ANG_W-1:0]   row;
	logic signed [ANG_W-1:0]   beta;
	logic signed [ANG_W-1:0]   sigma;
	logic signed [ANG_W-1:0]   abd;
	flag_t                 flag7;

	logic signed [ANG_EXT_W-1:0] theta_s8;
	logic signed [ANG_EXT_W-1:0] omega_s8;
	logic signed [ANG_EXT_W-1:0] row_s8;
	logic                        bad_s8;
	logic signed [ANG_EXT_W-1:0] phi;

	logic signed [ANG_EXT_W-1:0] ab_s9;
	logic signed [ANG_EXT_W-1:0] hip_s9;
	logic signed [ANG_EXT_W-1:0] phi_s9;
	logic                        bad_s9;

	logic signed [ANG_EXT_W-1:0] ab_s10;
	logic signed [ANG_EXT_W-1:0] hip_s10;
	logic signed [ANG_EXT_W-1:0] knee_s10;
	logic                        bad_s10;

	logic signed [FIELD_W-1:0]   ab_s11;
	logic signed [FIELD_W-1:0]   hip_s11;
	logic signed [FIELD_W-1:0]   knee_s11;
	logic                        bad_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leg_position_q <= POS_FRONT_RIGHT;
			upper_q <= LINK_W'(1600);
			lower_q <= LINK_W'(1600);
			offset_q <= LINK_W'(960);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_LEG_POSITION: leg_position_q <= cfg_data[1:0];
				REG_UPPER_LINK: upper_q <= cfg_data[LINK_W-1:0];
				REG_LOWER_LINK: lower_q <= cfg_data[LINK_W-1:0];
				REG_ABDUCTION_OFFSET: offset_q <= cfg_data[LINK_W-1:0];
				default: ;
			endcase
		end
	end

	assign lsum = {1'b0, upper_q} + {1'b0, lower_q};
	assign ldif = (upper_q >= lower_q) ? upper_q - lower_q : lower_q - upper_q;

	always_ff @(posedge clk) begin
		l1sq_q <= upper_q * upper_q;
		l2sq_q <= lower_q * lower_q;
		l3sq_q <= offset_q * offset_q;
		sum2_q <= lsum * lsum;
		dif2_q <= ldif * ldif;
		lzero_q <= (upper_q == '0) || (lower_q == '0);
	end

	assign en = !vld_q[PIPE_DEPTH-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid};
		end
	end

	assign right_leg = (leg_position_q == POS_FRONT_RIGHT) || (leg_position_q == POS_BACK_RIGHT);
	assign mirror_leg = (leg_position_q == POS_FRONT_RIGHT) || (leg_position_q == POS_BACK_LEFT);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= right_leg ? -17'(foot_x) : 17'(foot_x);
			y_s1 <= foot_y;
			z_s1 <= foot_z;
		end
	end

	assign xp = x_s1 * x_s1;
	assign yp = y_s1 * y_s1;
	assign zp = z_s1 * z_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s2 <= xp[30:0];
			yy_s2 <= yp[30:0];
			zz_s2 <= zp[30:0];
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			z_s2 <= z_s1;
		end
	end

	assign q_sum = 32'(xx_s2) + 32'(zz_s2);
	assign qy_sum = 33'(q_sum) + 33'(yy_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			q_s3 <= q_sum;
			d2_s3 <= $signed({1'b0, qy_sum}) - $signed({6'b0, l3sq_q});
			e2_s3 <= $signed({2'b0, q_sum}) - $signed({6'b0, l3sq_q});
			x_s3 <= x_s2;
			y_s3 <= y_s2;
			z_s3 <= z_s2;
		end
	end

	assign bad3 = lzero_q || (q_s3 == '0) || (q_s3 < 32'(l3sq_q)) || (d2_s3 <= 0) ||
		(d2_s3 < $signed({6'b0, dif2_q})) || (d2_s3 > $signed({4'b0, sum2_q}));
	assign um = $signed({4'b0, sum2_q}) - d2_s3;
	assign wm = d2_s3 - $signed({6'b0, dif2_q});
	assign am = $signed({6'b0, l1sq_q}) + d2_s3 - $signed({6'b0, l2sq_q});
	assign bm = $signed({6'b0, l1sq_q}) + $signed({6'b0, l2sq_q}) - d2_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			bad_s4 <= bad3;
			u_s4 <= bad3 ? '0 : um[29:0];
			w_s4 <= bad3 ? '0 : wm[29:0];
			a_s4 <= am;
			b_s4 <= bm;
			e2_s4 <= bad3 ? '0 : e2_s3[31:0];
			x_s4 <= x_s3;
			y_s4 <= y_s3;
			z_s4 <= z_s3;
		end
	end

	assign uw = u_s4 * w_s4;
	assign xe4 = AT_IN_W'(x_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5 <= SQ_IN_W'(uw);
			erad_s5 <= SQ_IN_W'({e2_s4, 24'b0});
			side_s5.a <= a_s4;
			side_s5.b <= b_s4;
			side_s5.ny <= -(AT_IN_W'(y_s4) <<< 12);
			side_s5.nz <= -AT_IN_W'(z_s4);
			side_s5.ax <= x_s4[16] ? -xe4 : xe4;
			side_s5.xzero <= (x_s4 == '0);
			side_s5.bad <= bad_s4;
		end
	end

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		logic [SQ_IN_W-1:0]  prad_i;
		logic [SQ_REM_W-1:0] prem_i;
		logic [SQ_STEPS-1:0] proot_i;
		logic [SQ_IN_W-1:0]  erad_i;
		logic [SQ_REM_W-1:0] erem_i;
		logic [SQ_STEPS-1:0] eroot_i;
		side_t               side_i;
		if (k == 0) begin : g_first
			assign prad_i = prod_s5;
			assign prem_i = '0;
			assign proot_i = '0;
			assign erad_i = erad_s5;
			assign erem_i = '0;
			assign eroot_i = '0;
			assign side_i = side_s5;
		end else begin : g_next
			assign prad_i = pr_rad[k-1];
			assign prem_i = pr_rem[k-1];
			assign proot_i = pr_root[k-1];
			assign erad_i = er_rad[k-1];
			assign erem_i = er_rem[k-1];
			assign eroot_i = er_root[k-1];
			assign side_i = sd_s6[k-1];
		end
		lik_sqrt_cell u_prod_cell (
			.clk      (clk),
			.en       (en),
			.rad_in   (prad_i),
			.rem_in   (prem_i),
			.root_in  (proot_i),
			.rad_out  (pr_rad[k]),
			.rem_out  (pr_rem[k]),
			.root_out (pr_root[k])
		);
		lik_sqrt_cell u_dist_cell (
			.clk      (clk),
			.en       (en),
			.rad_in   (erad_i),
			.rem_in   (erem_i),
			.root_in  (eroot_i),
			.rad_out  (er_rad[k]),
			.rem_out  (er_rem[k]),
			.root_out (er_root[k])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				sd_s6[k] <= side_i;
			end
		end
	end

	assign side6 = sd_s6[SQ_STEPS-1];
	assign s_ext = AT_IN_W'(pr_root[SQ_STEPS-1]);
	assign es_ext = AT_IN_W'(er_root[SQ_STEPS-1]);
	assign l3_ext = AT_IN_W'({offset_q, 12'b0});

	lik_atan2 u_alpha (.clk(clk), .en(en), .y_in(s_ext), .x_in(side6.a), .angle(alpha));
	lik_atan2 u_row (.clk(clk), .en(en), .y_in(s_ext), .x_in(side6.b), .angle(row));
	lik_atan2 u_beta (.clk(clk), .en(en), .y_in(side6.ny), .x_in(es_ext), .angle(beta));
	lik_atan2 u_sigma (.clk(clk), .en(en), .y_in(es_ext), .x_in(l3_ext), .angle(sigma));
	lik_atan2 u_abd (.clk(clk), .en(en), .y_in(side6.nz), .x_in(side6.ax), .angle(abd));

	for (genvar m = 0; m < AT_LAT; m++) begin : g_flag
		always_ff @(posedge clk) begin
			if (en) begin
				if (m == 0) begin
					fd_s7[m] <= '{xzero: side6.xzero, bad: side6.bad};
				end else begin
					fd_s7[m] <= fd_s7[(m == 0) ? 0 : m-1];
				end
			end
		end
	end

	assign flag7 = fd_s7[AT_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			theta_s8 <= ANG_EXT_W'(DEG_90) - ANG_EXT_W'(alpha) - ANG_EXT_W'(beta);
			omega_s8 <= ANG_EXT_W'(sigma) - (flag7.xzero ? ANG_EXT_W'(DEG_90) : ANG_EXT_W'(abd));
			row_s8 <= ANG_EXT_W'(row);
			bad_s8 <= flag7.bad;
		end
	end

	assign phi = row_s8 - theta_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			ab_s9 <= mirror_leg ? ANG_EXT_W'(DEG_90) - omega_s8 : ANG_EXT_W'(DEG_90) + omega_s8;
			hip_s9 <= right_leg ? ANG_EXT_W'(DEG_90) + theta_s8 : ANG_EXT_W'(DEG_90) - theta_s8;
			phi_s9 <= phi;
			bad_s9 <= bad_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ab_s10 <= ab_s9;
			hip_s10 <= hip_s9;
			knee_s10 <= right_leg ? ANG_EXT_W'(DEG_180) - phi_s9 : phi_s9;
			bad_s10 <= bad_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ab_s11 <= bad_s10 ? '0 : to_out(ab_s10);
			hip_s11 <= bad_s10 ? '0 : to_out(hip_s10);
			knee_s11 <= bad_s10 ? '0 : to_out(knee_s10);
			bad_s11 <= bad_s10;
		end
	end

	assign abduction_servo_angle = ab_s11;
	assign hip_servo_angle = hip_s11;
	assign knee_servo_angle = knee_s11;
	assign unreachable = bad_s11;

`ifndef SYNTHESIS
	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unreachable |-> abduction_servo_angle == '0 &&
		hip_servo_angle == '0 && knee_servo_angle == '0)
		else $error("unreachable result carries nonzero angles");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> abduction_servo_angle >= -OUT_LIM && abduction_servo_angle <= OUT_LIM &&
		hip_servo_angle >= -OUT_LIM && hip_servo_angle <= OUT_LIM &&
		knee_servo_angle >= -OUT_LIM && knee_servo_angle <= OUT_LIM)
		else $error("servo angle outside saturation range");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline advanced during stall");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted transaction lost at pipeline entry");
`endif

endmodule

// ===== tb/leg_inverse_kinematics_3dof_checker.sv =====
`timescale 1ns / 1ps

module leg_inverse_kinematics_3dof_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [lik_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [lik_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic signed [lik_pkg::FIELD_W-1:0]   foot_x,
	input  logic signed [lik_pkg::FIELD_W-1:0]   foot_y,
	input  logic signed [lik_pkg::FIELD_W-1:0]   foot_z,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic signed [lik_pkg::FIELD_W-1:0]   abduction_servo_angle,
	input  logic signed [lik_pkg::FIELD_W-1:0]   hip_servo_angle,
	input  logic signed [lik_pkg::FIELD_W-1:0]   knee_servo_angle,
	input  logic                                 unreachable,
	output int                                   fail_count,
	output int                                   pending_angles
);
	import lik_pkg::*;

	typedef struct packed {
		logic signed [FIELD_W-1:0] abd;
		logic signed [FIELD_W-1:0] hip;
		logic signed [FIELD_W-1:0] knee;
		logic                      unr;
	} servo_set_t;

	localparam longint NORM_MAX = longint'(1) << NORM_EXP;

	servo_set_t angle_q[$];
	logic [1:0] pos_reg;
	longint     thigh_len, shank_len, offset_len;

	function automatic longint deg_au(input longint d);
		return d * (longint'(1) << AU_BITS);
	endfunction

	function automatic longint abs64(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint floor_sqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = longint'(1) << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint cordic_atan2(input longint yv, input longint xv);
		longint acc, xs, ys;
		acc = 0;
		if (xv == 0 && yv == 0)
			return 0;
		if (xv < 0) begin
			acc = (yv >= 0) ? deg_au(180) : -deg_au(180);
			xv = -xv;
			yv = -yv;
		end
		while (abs64(xv) < NORM_MAX && abs64(yv) < NORM_MAX) begin
			xv *= 2;
			yv *= 2;
		end
		for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
			xs = xv >>> i;
			ys = yv >>> i;
			if (yv >= 0) begin
				xv += ys;
				yv -= xs;
				acc += longint'(atan_entry(SH_W'(i)));
			end else begin
				xv -= ys;
				yv += xs;
				acc -= longint'(atan_entry(SH_W'(i)));
			end
		end
		return acc;
	endfunction

	function automatic logic signed [FIELD_W-1:0] round_sat(input longint v);
		longint r, lim;
		lim = 360 * (longint'(1) << ANGLE_FRACTION_BITS);
		if (lim > 32767) lim = 32767;
		r = (v + (longint'(1) << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return FIELD_W'(r);
	endfunction

	function automatic servo_set_t solve_leg(input longint x, input longint y, input longint z);
		servo_set_t res;
		longint q, d2, e2, sum2, dif2, es, s, a, b;
		longint alpha, beta, row, sigma, theta, phi, omega, ab, hp, kn;
		res = '{abd: '0, hip: '0, knee: '0, unr: 1'b1};
		if (pos_reg == POS_FRONT_RIGHT || pos_reg == POS_BACK_RIGHT)
			x = -x;
		q = x * x + z * z;
		d2 = q + y * y - offset_len * offset_len;
		sum2 = (thigh_len + shank_len) * (thigh_len + shank_len);
		dif2 = (thigh_len - shank_len) * (thigh_len - shank_len);
		if (thigh_len == 0 || shank_len == 0 || q == 0 || q < offset_len * offset_len ||
				d2 <= 0 || d2 < dif2 || d2 > sum2)
			return res;
		e2 = q - offset_len * offset_len;
		es = floor_sqrt(longint'(e2) << 24);
		s = floor_sqrt((sum2 - d2) * (d2 - dif2));
		a = thigh_len * thigh_len + d2 - shank_len * shank_len;
		b = thigh_len * thigh_len + shank_len * shank_len - d2;
		alpha = cordic_atan2(s, a);
		row = cordic_atan2(s, b);
		beta = cordic_atan2(-y * 4096, es);
		sigma = cordic_atan2(es, offset_len * 4096);
		theta = deg_au(90) - alpha - beta;
		phi = row - theta;
		omega = sigma - ((x != 0) ? cordic_atan2(-z, abs64(x)) : deg_au(90));
		case (pos_reg)
			POS_FRONT_RIGHT: begin
				ab = deg_au(90) - omega; hp = deg_au(90) + theta; kn = deg_au(180) - phi;
			end
			POS_FRONT_LEFT: begin
				ab = deg_au(90) + omega; hp = deg_au(90) - theta; kn = phi;
			end
			POS_BACK_RIGHT: begin
				ab = deg_au(90) + omega; hp = deg_au(90) + theta; kn = deg_au(180) - phi;
			end
			default: begin
				ab = deg_au(90) - omega; hp = deg_au(90) - theta; kn = phi;
			end
		endcase
		res.abd = round_sat(ab);
		res.hip = round_sat(hp);
		res.knee = round_sat(kn);
		res.unr = 1'b0;
		return res;
	endfunction

	assign pending_angles = angle_q.size();

	always @(posedge clk or negedge arst_n) begin
		servo_set_t want;
		if (!arst_n) begin
			pos_reg <= POS_FRONT_RIGHT;
			thigh_len = 1600;
			shank_len = 1600;
			offset_len = 960;
			fail_count <= 0;
			angle_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (angle_q.size() == 0) begin
					$display("%0t: unexpected transaction abd=%0d hip=%0d knee=%0d unr=%0b",
						$time, abduction_servo_angle, hip_servo_angle, knee_servo_angle,
						unreachable);
					fail_count <= fail_count + 1;
				end else begin
					want = angle_q.pop_front();
					if (want !== {abduction_servo_angle, hip_servo_angle, knee_servo_angle,
							unreachable}) begin
						$display("%0t: mismatch expected abd=%0d hip=%0d knee=%0d unr=%0b",
							$time, want.abd, want.hip, want.knee, want.unr);
						$display("%0t:          actual   abd=%0d hip=%0d knee=%0d unr=%0b",
							$time, abduction_servo_angle, hip_servo_angle, knee_servo_angle,
							unreachable);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready)
				angle_q.push_back(solve_leg(longint'(foot_x), longint'(foot_y),
					longint'(foot_z)));
			if (cfg_write) begin
				case (cfg_index)
					REG_LEG_POSITION: pos_reg <= cfg_data[1:0];
					REG_UPPER_LINK: thigh_len = cfg_data;
					REG_LOWER_LINK: shank_len = cfg_data;
					REG_ABDUCTION_OFFSET: offset_len = cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== tb/leg_inverse_kinematics_3dof_tb.sv =====
`timescale 1ns / 1ps

module leg_inverse_kinematics_3dof_tb;
	import lik_pkg::*;

	localparam int SETTLE_CYCLES = 2 * PIPE_DEPTH + 20;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [FIELD_W-1:0] foot_x = '0, foot_y = '0, foot_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [FIELD_W-1:0] abduction_servo_angle, hip_servo_angle, knee_servo_angle;
	logic unreachable;
	int fail_count, pending_angles;
	int send_idle_pct = 14, recv_idle_pct = 83;
	logic recv_hold = 1'b0;
	longint cycle_count = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	leg_inverse_kinematics_3dof dut (.*);

	leg_inverse_kinematics_3dof_checker checker_i (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n)
			out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (pending_angles != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_target(input int x, input int y, input int z, input bit gaps);
		while (gaps && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		foot_x <= FIELD_W'(x);
		foot_y <= FIELD_W'(y);
		foot_z <= FIELD_W'(z);
		@(posedge clk iff in_ready);
	endtask

	task automatic random_target(output int x, output int y, output int z);
		int r, l;
		r = $urandom_range(99);
		l = 4000;
		if (r < 15) begin
			x = $signed(16'($urandom));
			y = $signed(16'($urandom));
			z = $signed(16'($urandom));
		end else if (r < 25) begin
			x = $urandom_range(1) ? 0 : $urandom_range(20) - 10;
			y = $urandom_range(4000) - 2000;
			z = $urandom_range(8000) - 4000;
		end else begin
			x = $urandom_range(2 * l) - l;
			y = $urandom_range(2 * l) - l;
			z = -int'($urandom_range(4200, 500));
			if ($urandom_range(3) == 0) z = -z;
		end
	endtask

	task automatic random_phase(input int n);
		int x, y, z;
		for (int i = 0; i < n; i++) begin
			random_target(x, y, z);
			send_target(x, y, z, 1'b1);
		end
	endtask

	initial begin
		int x, y, z;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_target(0, 0, -2500, 1'b0);
		send_target(0, 0, 0, 1'b0);
		send_target(-32768, -32768, -32768, 1'b0);
		send_target(32767, 32767, 32767, 1'b0);
		send_target(-1, -1, -1, 1'b0);
		send_target(0, 200, -2600, 1'b0);
		send_target(0, 200, 2600, 1'b0);
		send_target(100, 0, -960, 1'b0);
		send_target(960, 0, 0, 1'b0);
		send_target(500, 300, -3300, 1'b0);
		send_target(-500, -300, -1200, 1'b0);
		send_target(1000, 0, -3339, 1'b0);
		send_target(0, 0, -960, 1'b0);
		send_target(21845, -21846, 10922, 1'b0);
		drain_pipe();

		for (int p = 0; p < 4; p++) begin
			write_reg(REG_LEG_POSITION, p);
			send_target(300, -400, -2500, 1'b0);
			send_target(-300, 400, -2500, 1'b0);
			send_target(0, 100, -2400, 1'b0);
			drain_pipe();
		end
		write_reg(REG_UPPER_LINK, 16383);
		write_reg(REG_LOWER_LINK, 1);
		write_reg(REG_ABDUCTION_OFFSET, 0);
		send_target(0, 16383, 0, 1'b0);
		send_target(1000, 16000, -1000, 1'b0);
		drain_pipe();
		write_reg(REG_UPPER_LINK, 1);
		write_reg(REG_LOWER_LINK, 16383);
		write_reg(REG_ABDUCTION_OFFSET, 16383);
		send_target(16383, 16383, 100, 1'b0);
		send_target(-20000, 5000, 15000, 1'b0);
		drain_pipe();

		write_reg(REG_UPPER_LINK, 1600);
		write_reg(REG_LOWER_LINK, 1600);
		write_reg(REG_ABDUCTION_OFFSET, 960);
		write_reg(REG_LEG_POSITION, POS_FRONT_LEFT);
		random_phase(200);
		drain_pipe();

		send_idle_pct = 83;
		recv_idle_pct = 14;
		write_reg(REG_LEG_POSITION, POS_BACK_RIGHT);
		write_reg(REG_UPPER_LINK, 2200);
		write_reg(REG_LOWER_LINK, 1800);
		write_reg(REG_ABDUCTION_OFFSET, 500);
		random_phase(200);
		drain_pipe();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_LEG_POSITION, POS_BACK_LEFT);
		write_reg(REG_UPPER_LINK, 1500);
		write_reg(REG_LOWER_LINK, 2500);
		write_reg(REG_ABDUCTION_OFFSET, 1200);
		fork
			begin
				recv_hold <= 1'b1;
				repeat (3 * PIPE_DEPTH) @(posedge clk);
				recv_hold <= 1'b0;
			end
			random_phase(200);
		join
		drain_pipe();

		write_reg(REG_LEG_POSITION, POS_FRONT_RIGHT);
		write_reg(REG_UPPER_LINK, 1600);
		write_reg(REG_LOWER_LINK, 1600);
		write_reg(REG_ABDUCTION_OFFSET, 960);
		random_phase(200);
		drain_pipe();

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
